/* rtl/hkt_pkg.sv */
// Shared types, codes and constants for the hashed key table.
`default_nettype none
package hkt_pkg;

  // Hash constants: the FNV-1a 64-bit prime with a basis other than the FNV-1a one. The prime is 2^40 + PRIME_LO.
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
  localparam int unsigned FNV_PRIME_SHIFT = 40;

  // Load limit: grow when (count+1)*GROW_NUM >= capacity*GROW_DEN.
  localparam logic [19:0] GROW_NUM = 20'd10;
  localparam logic [19:0] GROW_DEN = 20'd7;

  // Operation codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One entry of the entry store.
  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] value;
    logic [63:0] hash;
  } entry_data_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DECIDE,
    ST_RB_ENT,
    ST_RB_HASH,
    ST_P_RD,
    ST_P_CHK,
    ST_F_RD,
    ST_F_SLOT,
    ST_F_ENT,
    ST_DONE
  } hkt_state_t;

endpackage
`default_nettype wire

/* rtl/hkt_hash.sv */
// Iterative 64-bit hash unit with FNV-1a arithmetic on its own basis, one key byte per cycle.
`default_nettype none
module hkt_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] key,
  input  wire logic [3:0]  len,
  output logic             done,
  output logic [63:0]      hash
);
  import hkt_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [3:0]  len_q;
  logic [63:0] key_sh;
  logic [63:0] hx;

  // Fold in one byte, then multiply by the prime as a shift plus a small product.
  assign hx = hash ^ {56'd0, key_sh[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        len_q  <= len;
        key_sh <= key;
        hash   <= FNV_BASIS;
      end else if (busy) begin
        if (cnt == len_q) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          hash   <= (hx << FNV_PRIME_SHIFT) + (hx * 64'(FNV_PRIME_LO));
          key_sh <= key_sh >> 8;
          cnt    <= cnt + 4'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/hkt_index_mem.sv */
// Index slot memory: one write and one registered read per cycle.
`default_nettype none
module hkt_index_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/hkt_entry_mem.sv */
// Entry store holding key, length, value and hash of each entry.
`default_nettype none
module hkt_entry_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire hkt_pkg::entry_data_t wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output hkt_pkg::entry_data_t      rd_data
);
  import hkt_pkg::*;

  entry_data_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/hashed_key_table_linear_probe_core.sv */
// Top level of the hashed key table with a linearly probed index.
// Each transfer is an insert or a find of a key of up to eight bytes. The key
// is hashed at one byte per cycle with FNV-1a arithmetic on its own basis, then
// the index memory is probed one slot at a time; a find also reads the entry
// store once per occupied slot. An insert that grows the index first clears the
// new capacity (one slot a cycle) and re-inserts every stored entry by probing.
// After reset the whole index memory is cleared before the first transfer is
// taken. One item is handled at a time; the next is taken once its result sits
// in the output register, even while that result is still stalled.
// MAX_INDEX_SLOTS and FIRST_INDEX_SLOTS must be powers of two.
`default_nettype none
module hashed_key_table_linear_probe_core #(
  parameter int unsigned MAX_ENTRIES       = 256,
  parameter int unsigned MAX_INDEX_SLOTS   = 512,
  parameter int unsigned MAX_KEY_BYTES     = 8,
  parameter int unsigned FIRST_INDEX_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [63:0] key_bytes,
  input  wire logic [3:0]  key_length,
  input  wire logic [31:0] value_ref,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [7:0]       entry_index,
  output logic [31:0]      found_value,
  output logic [63:0]      key_hash,
  output logic             status
);
  import hkt_pkg::*;

  localparam int unsigned EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW   = $clog2(MAX_INDEX_SLOTS);
  localparam int unsigned CAPW = $clog2(MAX_INDEX_SLOTS + 1);

  hkt_state_t state, state_next;

  // Control registers.
  logic [CAPW-1:0] cap;
  logic [CW-1:0]   count;
  logic [SW-1:0]   clr;
  logic            rb;

  // Work registers of the current item.
  logic            k_func;
  logic [63:0]     k_key;
  logic [3:0]      k_len;
  logic [31:0]     k_val;
  logic [63:0]     h_reg;
  logic [SW-1:0]   slot;
  logic [CAPW-1:0] n;
  logic            probe_rb;
  logic [CW-1:0]   rb_i;
  logic [CW-1:0]   e_reg;
  logic            r_found;
  logic [EW-1:0]   r_eidx;
  logic [31:0]     r_fval;
  logic            r_status;

  // Memory and hash unit connections.
  logic            idx_we;
  logic [SW-1:0]   idx_wr_addr;
  logic [CW-1:0]   idx_wr_data;
  logic [CW-1:0]   idx_rdata;
  logic            ent_we;
  logic [EW-1:0]   ent_rd_addr;
  entry_data_t     ent_wr_data;
  entry_data_t     ent_rdata;
  logic            hash_start;
  logic            hash_done;
  logic [63:0]     hash_value;

  // Input key clean-up: saturate the length and drop bytes past it.
  logic [3:0]  len_c;
  logic [63:0] key_c;

  always_comb begin
    len_c = (32'(key_length) > MAX_KEY_BYTES) ? 4'(MAX_KEY_BYTES) : key_length;
    for (int i = 0; i < 8; i++) begin
      key_c[8*i +: 8] = (4'(i) < len_c) ? key_bytes[8*i +: 8] : 8'd0;
    end
  end

  // Derived probe quantities.
  logic [SW-1:0]   mask;
  logic [SW-1:0]   home_slot;
  logic [SW-1:0]   slot_inc;
  logic [SW-1:0]   clr_last;
  logic            n_last;
  logic            rb_last;
  logic            slot_empty;
  logic            key_match;
  logic [19:0]     grow_lhs;
  logic [19:0]     grow_rhs;
  logic [CAPW:0]   cap2;
  logic [CAPW-1:0] new_cap;
  logic            grow;
  logic            out_free;
  logic [31:0]     eidx_w;

  always_comb begin
    mask       = SW'(cap - CAPW'(1));
    home_slot  = h_reg[SW-1:0] & mask;
    slot_inc   = (slot + SW'(1)) & mask;
    clr_last   = rb ? SW'(cap - CAPW'(1)) : SW'(MAX_INDEX_SLOTS - 1);
    n_last     = (CAPW'(n + CAPW'(1)) == cap);
    rb_last    = (CW'(rb_i + CW'(1)) == count);
    slot_empty = (idx_rdata == '0);
    key_match  = (ent_rdata.len == k_len) && (ent_rdata.key == k_key);
    grow_lhs   = (20'(count) + 20'd1) * GROW_NUM;
    grow_rhs   = 20'(cap) * GROW_DEN;
    cap2       = {cap, 1'b0};
    if (cap == '0) begin
      new_cap = CAPW'(FIRST_INDEX_SLOTS);
    end else if (32'(cap2) > MAX_INDEX_SLOTS) begin
      new_cap = CAPW'(MAX_INDEX_SLOTS);
    end else begin
      new_cap = cap2[CAPW-1:0];
    end
    grow     = (grow_lhs >= grow_rhs) && (new_cap != cap);
    out_free = !out_valid || !out_stall;
    eidx_w   = 32'(r_eidx);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == clr_last) begin
          if (!rb) begin
            state_next = ST_IDLE;
          end else if (count == '0) begin
            state_next = ST_P_RD;
          end else begin
            state_next = ST_RB_ENT;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (k_func == FUNC_FIND) begin
          state_next = (cap == '0) ? ST_DONE : ST_F_RD;
        end else if (32'(count) >= MAX_ENTRIES) begin
          state_next = ST_DONE;
        end else if (grow) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_P_RD;
        end
      end
      ST_RB_ENT:  state_next = ST_RB_HASH;
      ST_RB_HASH: state_next = ST_P_RD;
      ST_P_RD:    state_next = ST_P_CHK;
      ST_P_CHK: begin
        if (slot_empty || n_last) begin
          if (probe_rb) begin
            state_next = rb_last ? ST_P_RD : ST_RB_ENT;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          state_next = ST_P_RD;
        end
      end
      ST_F_RD: state_next = ST_F_SLOT;
      ST_F_SLOT: begin
        state_next = slot_empty ? ST_DONE : ST_F_ENT;
      end
      ST_F_ENT: begin
        if (key_match || n_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_F_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory, hash unit and handshake controls.
  always_comb begin
    in_stall    = (state != ST_IDLE);
    hash_start  = (state == ST_IDLE) && in_valid;
    idx_we      = (state == ST_CLEAR) || ((state == ST_P_CHK) && slot_empty);
    idx_wr_addr = (state == ST_CLEAR) ? clr : slot;
    if (state == ST_CLEAR) begin
      idx_wr_data = '0;
    end else if (probe_rb) begin
      idx_wr_data = CW'(rb_i + CW'(1));
    end else begin
      idx_wr_data = CW'(count + CW'(1));
    end
    ent_we      = (state == ST_P_CHK) && slot_empty && !probe_rb;
    ent_rd_addr = (state == ST_RB_ENT) ? rb_i[EW-1:0] : EW'(idx_rdata - CW'(1));
    ent_wr_data = '{key: k_key, len: k_len, value: k_val, hash: h_reg};
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cap       <= '0;
      count     <= '0;
      clr       <= '0;
      rb        <= 1'b0;
    end else begin
      // The output register fills from the result state and empties on a transfer.
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr == clr_last) begin
            clr      <= '0;
            rb       <= 1'b0;
            rb_i     <= '0;
            slot     <= home_slot;
            n        <= '0;
            probe_rb <= 1'b0;
          end else begin
            clr <= clr + SW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            k_func   <= func;
            k_key    <= key_c;
            k_len    <= len_c;
            k_val    <= value_ref;
            r_found  <= 1'b0;
            r_eidx   <= '0;
            r_fval   <= '0;
            r_status <= STATUS_OK;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            h_reg <= hash_value;
          end
        end
        ST_DECIDE: begin
          n        <= '0;
          slot     <= home_slot;
          probe_rb <= 1'b0;
          if (k_func == FUNC_INSERT) begin
            if (32'(count) >= MAX_ENTRIES) begin
              r_status <= STATUS_FULL;
            end else if (grow) begin
              cap <= new_cap;
              rb  <= 1'b1;
            end
          end
        end
        ST_RB_ENT: begin
        end
        ST_RB_HASH: begin
          slot     <= ent_rdata.hash[SW-1:0] & mask;
          n        <= '0;
          probe_rb <= 1'b1;
        end
        ST_P_RD: begin
        end
        ST_P_CHK: begin
          if (slot_empty || n_last) begin
            if (probe_rb) begin
              // Move on to the next entry, or to the new key after the last one.
              rb_i <= CW'(rb_i + CW'(1));
              if (rb_last) begin
                slot     <= home_slot;
                n        <= '0;
                probe_rb <= 1'b0;
              end
            end else if (slot_empty) begin
              r_eidx <= count[EW-1:0];
              count  <= CW'(count + CW'(1));
            end else begin
              r_status <= STATUS_FULL;
            end
          end else begin
            n    <= CAPW'(n + CAPW'(1));
            slot <= slot_inc;
          end
        end
        ST_F_RD: begin
        end
        ST_F_SLOT: begin
          e_reg <= idx_rdata;
        end
        ST_F_ENT: begin
          if (key_match) begin
            r_found <= 1'b1;
            r_eidx  <= EW'(e_reg - CW'(1));
            r_fval  <= ent_rdata.value;
          end else begin
            n    <= CAPW'(n + CAPW'(1));
            slot <= slot_inc;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            found       <= r_found;
            entry_index <= eidx_w[7:0];
            found_value <= r_fval;
            key_hash    <= h_reg;
            status      <= r_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

  hkt_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_c),
    .len   (len_c),
    .done  (hash_done),
    .hash  (hash_value)
  );

  hkt_index_mem #(
    .DEPTH (MAX_INDEX_SLOTS),
    .AW    (SW),
    .DW    (CW)
  ) u_index (
    .clk     (clk),
    .wr_en   (idx_we),
    .wr_addr (idx_wr_addr),
    .wr_data (idx_wr_data),
    .rd_addr (slot),
    .rd_data (idx_rdata)
  );

  hkt_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (EW)
  ) u_entry (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (count[EW-1:0]),
    .wr_data (ent_wr_data),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rdata)
  );

  // The entry count never passes the store size.
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= MAX_ENTRIES)
    else $error("entry count beyond entry store size");

  // The index capacity is zero or a power of two.
  assert property (@(posedge clk) disable iff (rst) $onehot0(cap))
    else $error("index capacity is not a power of two");

  // An accepted transfer closes the input until its work is done.
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer accepted while busy");

  // Leaving the result state always presents a result.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && state_next == ST_IDLE) |=> out_valid)
    else $error("result lost on the way out");

endmodule
`default_nettype wire
